>>> rtl/core/bpsf_pkg.sv
// Shared types and constants for the bitmap pixel stream filter.
package bpsf_pkg;

  localparam int WIDTH_W     = 13;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int CMD_DEPTH   = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_PIXELS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_BYTES  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_MODE  = 2'd2;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET       = 13'd1;
  localparam logic [2:0]         PIXEL_BYTES_RESET = 3'd3;
  localparam logic [2:0]         PIXEL_BYTES_BGRA  = 3'd4;

  localparam logic [1:0] CH_BLUE  = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_RED   = 2'd2;
  localparam logic [1:0] CH_ALPHA = 2'd3;

  // floor(s / 3) equals (s * 683) >> 11 for every s up to 765.
  localparam logic [10:0] DIV3_MUL   = 11'd683;
  localparam int          DIV3_SHIFT = 11;

  typedef enum logic {
    CMD_PAD,
    CMD_PIXEL
  } cmd_kind_t;

  typedef enum logic [1:0] {
    MODE_GRAY   = 2'd0,
    MODE_ROTATE = 2'd1,
    MODE_INVERT = 2'd2,
    MODE_PASS   = 2'd3
  } filter_mode_t;

  typedef struct packed {
    cmd_kind_t    kind;
    filter_mode_t mode;
    logic         has_alpha;
    logic [7:0]   blue;
    logic [7:0]   green;
    logic [7:0]   red;
    logic [7:0]   alpha;
    logic [9:0]   sum;
  } cmd_t;

endpackage

>>> rtl/core/bpsf_front.sv
// Front end: configuration registers, pixel gathering and row padding tracking.
module bpsf_front #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic [7:0]                       in_byte,
  input  logic                             cfg_we,
  input  logic [bpsf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bpsf_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                             cmd_wr,
  output bpsf_pkg::cmd_t                   cmd
);
  import bpsf_pkg::*;

  localparam int WIDTH_MAX = (1 << WIDTH_W) - 1;
  localparam int EFF_MAX   = (MAX_WIDTH < WIDTH_MAX) ? MAX_WIDTH : WIDTH_MAX;
  localparam int COL_W     = (EFF_MAX < 2) ? 1 : $clog2(EFF_MAX + 1);
  localparam logic [WIDTH_W-1:0] WIDTH_CAP = WIDTH_W'(EFF_MAX);

  logic [WIDTH_W-1:0] width_pixels;
  logic [2:0]         pixel_bytes;
  filter_mode_t       filter_mode;

  logic [COL_W-1:0] column, column_next;
  logic [1:0]       chan, chan_next;
  logic [1:0]       pad_left, pad_left_next;
  logic [7:0]       held_blue, held_blue_next;
  logic [7:0]       held_green, held_green_next;
  logic [7:0]       held_red, held_red_next;

  logic [WIDTH_W-1:0] width_nz;
  logic [WIDTH_W-1:0] eff_width;
  logic [WIDTH_W-1:0] column_inc;
  logic               row_done;
  logic               bgra;
  logic               finish;

  assign width_nz   = (width_pixels == '0) ? WIDTH_W'(1) : width_pixels;
  assign eff_width  = (width_nz > WIDTH_CAP) ? WIDTH_CAP : width_nz;
  assign column_inc = WIDTH_W'(column) + WIDTH_W'(1);
  assign row_done   = column_inc >= eff_width;
  assign bgra       = pixel_bytes == PIXEL_BYTES_BGRA;

  always_comb begin
    column_next     = column;
    chan_next       = chan;
    pad_left_next   = pad_left;
    held_blue_next  = held_blue;
    held_green_next = held_green;
    held_red_next   = held_red;
    finish          = 1'b0;
    cmd_wr          = 1'b0;
    cmd.kind        = CMD_PIXEL;
    cmd.mode        = filter_mode;
    cmd.has_alpha   = 1'b0;
    cmd.blue        = held_blue;
    cmd.green       = held_green;
    cmd.red         = in_byte;
    cmd.alpha       = 8'd0;
    if (in_valid) begin
      if (pad_left != 2'd0) begin
        pad_left_next = pad_left - 2'd1;
        cmd_wr        = 1'b1;
        cmd.kind      = CMD_PAD;
        cmd.blue      = in_byte;
      end else begin
        case (chan)
          CH_BLUE: begin
            held_blue_next = in_byte;
            chan_next      = CH_GREEN;
          end
          CH_GREEN: begin
            held_green_next = in_byte;
            chan_next       = CH_RED;
          end
          CH_RED: begin
            held_red_next = in_byte;
            if (bgra) begin
              chan_next = CH_ALPHA;
            end else begin
              finish = 1'b1;
            end
          end
          default: begin
            // Alpha always completes a pixel, even if the byte count changed.
            finish        = 1'b1;
            cmd.has_alpha = 1'b1;
            cmd.red       = held_red;
            cmd.alpha     = in_byte;
          end
        endcase
      end
    end
    if (finish) begin
      cmd_wr    = 1'b1;
      chan_next = CH_BLUE;
      if (row_done) begin
        column_next = '0;
        // A BGR row of w pixels needs (w mod 4) padding bytes; BGRA rows need none.
        pad_left_next = bgra ? 2'd0 : eff_width[1:0];
      end else begin
        column_next = column_inc[COL_W-1:0];
      end
    end
    cmd.sum = 10'(cmd.blue) + 10'(cmd.green) + 10'(cmd.red);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_pixels <= WIDTH_RESET;
      pixel_bytes  <= PIXEL_BYTES_RESET;
      filter_mode  <= MODE_GRAY;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH_PIXELS: width_pixels <= cfg_data[WIDTH_W-1:0];
        REG_PIXEL_BYTES:  pixel_bytes  <= cfg_data[2:0];
        REG_FILTER_MODE:  filter_mode  <= filter_mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column   <= '0;
      chan     <= CH_BLUE;
      pad_left <= 2'd0;
    end else begin
      column   <= column_next;
      chan     <= chan_next;
      pad_left <= pad_left_next;
    end
  end

  always_ff @(posedge clk) begin
    held_blue  <= held_blue_next;
    held_green <= held_green_next;
    held_red   <= held_red_next;
  end

endmodule

>>> rtl/core/bpsf_cmd_fifo.sv
// Short command queue between the front end and the output sequencer.
module bpsf_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  bpsf_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           rd,
  output bpsf_pkg::cmd_t rd_data,
  output logic           valid
);
  import bpsf_pkg::*;

  localparam int PTR_W = $clog2(CMD_DEPTH);
  localparam int CNT_W = $clog2(CMD_DEPTH + 1);

  cmd_t             mem [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = count == CNT_W'(CMD_DEPTH);
  assign valid   = count != '0;
  assign do_wr   = wr && !full;
  assign do_rd   = rd && valid;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

>>> rtl/core/bpsf_back.sv
// Back end: applies the filter, sends each pixel out one byte at a time and passes padding bytes through.
module bpsf_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  bpsf_pkg::cmd_t cmd,
  output logic           cmd_rd,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     out_byte,
  output logic           last_of_run
);
  import bpsf_pkg::*;

  logic [1:0]  idx;
  logic        out_valid;
  logic        load;
  logic [20:0] prod;
  logic [7:0]  gray;
  logic [7:0]  top;
  logic [7:0]  new_blue;
  logic [7:0]  new_green;
  logic [7:0]  new_red;
  logic [7:0]  sel_byte;
  logic        sel_last;

  assign prod = 21'(cmd.sum) * 21'(DIV3_MUL);
  assign gray = prod[DIV3_SHIFT+7:DIV3_SHIFT];
  assign top  = (cmd.alpha != 8'd0) ? cmd.alpha : 8'hFF;

  always_comb begin
    new_blue  = cmd.blue;
    new_green = cmd.green;
    new_red   = cmd.red;
    case (cmd.mode)
      MODE_GRAY: begin
        new_blue  = gray;
        new_green = gray;
        new_red   = gray;
      end
      MODE_ROTATE: begin
        new_red   = cmd.green;
        new_green = cmd.blue;
        new_blue  = cmd.red;
      end
      MODE_INVERT: begin
        new_blue  = top - cmd.blue;
        new_green = top - cmd.green;
        new_red   = top - cmd.red;
      end
      default: ;
    endcase
  end

  always_comb begin
    sel_byte = cmd.alpha;
    sel_last = cmd.has_alpha ? (idx == CH_ALPHA) : (idx == CH_RED);
    if (cmd.kind == CMD_PAD) begin
      sel_byte = cmd.blue;
      sel_last = 1'b1;
    end else begin
      case (idx)
        CH_BLUE:  sel_byte = new_blue;
        CH_GREEN: sel_byte = new_green;
        CH_RED:   sel_byte = new_red;
        default:  sel_byte = cmd.alpha;
      endcase
    end
  end

  // The output register refills in the same cycle that its byte is taken, if a command is waiting.
  assign load   = cmd_valid && (!out_valid || pop);
  assign cmd_rd = load && sel_last;
  assign empty  = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= CH_BLUE;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= sel_last ? CH_BLUE : idx + 2'd1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= sel_byte;
      last_of_run <= sel_last;
    end
  end

endmodule

>>> rtl/core/bmp_pixel_stream_filter.sv
// Bitmap pixel stream filter: gathers BGR(A) bytes, filters pixels, passes row padding.
// The byte that completes a pixel, or a padding byte, is queued as a command, and its
// first result reaches the result ports through the output register. Throughput: one
// byte per cycle in while full is low, and out while pop is high and commands wait;
// full rises only when the four-entry command queue holds four commands.
// Reset (rst, synchronous): registers return to width 1, BGR, grayscale; queues empty.
module bmp_pixel_stream_filter #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [7:0]                       in_byte,
  output logic                             empty,
  input  logic                             pop,
  output logic [7:0]                       out_byte,
  output logic                             last_of_run,
  input  logic                             cfg_we,
  input  logic [bpsf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bpsf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bpsf_pkg::*;

  logic in_valid;
  logic cmd_wr;
  cmd_t cmd_in;
  logic cmd_full;
  logic cmd_rd;
  cmd_t cmd_head;
  logic cmd_valid;

  assign in_valid = push && !full;
  assign full     = cmd_full;

  bpsf_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd_wr   (cmd_wr),
    .cmd      (cmd_in)
  );

  bpsf_cmd_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr     (cmd_wr),
    .wr_data(cmd_in),
    .full   (cmd_full),
    .rd     (cmd_rd),
    .rd_data(cmd_head),
    .valid  (cmd_valid)
  );

  bpsf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd_head),
    .cmd_rd     (cmd_rd),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .last_of_run(last_of_run)
  );

  // The front end only issues a command when the queue has room for it.
  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd_wr |-> !cmd_full)
    else $error("command written into a full queue");

  // The sequencer only retires a command that is really queued.
  a_no_read_when_empty: assert property (@(posedge clk) disable iff (rst)
    cmd_rd |-> cmd_valid)
    else $error("command retired from an empty queue");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> empty)
    else $error("result shown right after reset");

endmodule
